>>> hdl/swm_pkg.sv
// Shared types and codes for the sliding-window median block.
`timescale 1ns / 1ps

package swm_pkg;

    // Operation codes carried by the func field of a request.
    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } swm_func_t;

    // Broadcast command that every cell of the sorted chain sees in a cycle.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] sample;
    } swm_cmd_t;

endpackage

>>> hdl/swm_cell.sv
// One cell of the sorted sample chain: holds a sample, its age and an occupied flag.
`timescale 1ns / 1ps

module swm_cell #(
    parameter int AGE_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swm_pkg::swm_cmd_t cmd,
    input  logic [AGE_W-1:0]  oldest_age,
    // Neighbor toward the small end of the chain.
    input  logic [7:0]        left_sample,
    input  logic [AGE_W-1:0]  left_age,
    input  logic              left_occ,
    input  logic              left_keep,
    input  logic              passed_in,
    // Neighbor toward the large end of the chain.
    input  logic [7:0]        right_sample,
    input  logic [AGE_W-1:0]  right_age,
    input  logic              right_occ,
    // Own state and chain signals handed on.
    output logic [7:0]        val,
    output logic [AGE_W-1:0]  age,
    output logic              occ,
    output logic              keep,
    output logic              passed_out
);

    logic [7:0]       val_reg;
    logic [7:0]       val_next;
    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             occ_reg;
    logic             occ_next;
    logic             hit;

    // A cell keeps its place on a push when its sample is not above the new one.
    assign keep       = occ_reg && (val_reg <= cmd.sample);
    // The oldest sample is the one whose age equals the fill count minus one.
    assign hit        = occ_reg && (age_reg == oldest_age);
    assign passed_out = passed_in || hit;

    always_comb
    begin
        val_next = val_reg;
        age_next = age_reg;
        occ_next = occ_reg;
        if (cmd.push)
        begin
            if (keep)
            begin
                age_next = age_reg + AGE_W'(1);
            end
            else if (left_keep)
            begin
                val_next = cmd.sample;
                age_next = '0;
                occ_next = 1'b1;
            end
            else
            begin
                val_next = left_sample;
                age_next = left_age + AGE_W'(1);
                occ_next = left_occ;
            end
        end
        else if (cmd.pop)
        begin
            // Every cell at or beyond the removed one takes its right neighbor.
            if (passed_out)
            begin
                val_next = right_sample;
                age_next = right_age;
                occ_next = right_occ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign val = val_reg;
    assign age = age_reg;
    assign occ = occ_reg;

endmodule

>>> hdl/sliding_window_median.sv
// Top level of the sliding-window median: sorted cell chain, fill counter and result register.
`timescale 1ns / 1ps

// The block keeps a first-in-first-out window of up to WINDOW_DEPTH byte samples
// in a chain of cells that is always sorted in ascending order, each cell also
// holding the age of its sample. A request either pushes a sample, which every
// cell places at once by comparing against the new value and shifting up
// by one cell where needed, or pops the oldest sample, which the cell whose age
// equals the fill count minus one gives up while the cells above it shift down
// by one. One request is taken per clock cycle for as long as results are taken;
// a request first updates the chain, and its result is then registered by picking
// the middle cell into the output register. The achievable clock
// is set by the removal chain on a pop, which passes a flag through all
// WINDOW_DEPTH cells, and by the one-of-WINDOW_DEPTH median select. The median
// is the sample at ascending rank floor(count/2), 0 for an empty window. A push
// into a full window or a pop from an empty one leaves the window unchanged and
// returns rejected high. fill_count shows the low seven bits of the count. No
// clearing pass is needed after reset: the occupied flags clear at once.
module sliding_window_median #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // Request channel.
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       func,
    input  logic [7:0] sample,
    // Result channel.
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] median,
    output logic [6:0] fill_count,
    output logic       is_full,
    output logic       is_empty,
    output logic       rejected
);

    localparam int AGE_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    // Window fill count.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_less_one;
    logic [CNT_W-1:0] mid_rank;

    // A request whose chain update is done but whose result is not yet registered.
    logic             pend_reg;
    logic             pend_next;
    logic             pend_rej_reg;
    logic             pend_rej_next;

    // Result register.
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [7:0]       median_reg;
    logic [6:0]       fill_reg;
    logic             full_reg;
    logic             empty_reg;
    logic             rejected_reg;

    logic             req_take;
    logic             load_out;
    logic             win_full;
    logic             win_empty;
    logic             do_push;
    logic             do_pop;
    logic [7:0]       median_sel;

    swm_pkg::swm_cmd_t cmd;
    logic [AGE_W-1:0]  oldest_age;

    // Chain wires.
    logic [7:0]       cell_val    [WINDOW_DEPTH];
    logic [AGE_W-1:0] cell_age    [WINDOW_DEPTH];
    logic             cell_occ    [WINDOW_DEPTH];
    logic             cell_keep   [WINDOW_DEPTH];
    logic             cell_passed [WINDOW_DEPTH];

    assign win_full  = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign win_empty = (count_reg == '0);

    // The result of the pending request moves out when the output register is free
    // or is being emptied in this cycle; a new request may enter in the same cycle.
    assign load_out  = pend_reg && (!res_valid_reg || !res_stall);
    assign req_stall = pend_reg && !load_out;
    assign req_take  = req_valid && !req_stall;

    assign do_push = req_take && (func == swm_pkg::FUNC_PUSH) && !win_full;
    assign do_pop  = req_take && (func == swm_pkg::FUNC_POP) && !win_empty;

    assign cmd.push   = do_push;
    assign cmd.pop    = do_pop;
    assign cmd.sample = sample;

    assign count_less_one = count_reg - CNT_W'(1);
    assign oldest_age     = count_less_one[AGE_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = count_less_one;
        end
    end

    always_comb
    begin
        pend_next     = pend_reg;
        pend_rej_next = pend_rej_reg;
        if (req_take)
        begin
            pend_next     = 1'b1;
            pend_rej_next = !do_push && !do_pop;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    // The sorted chain. The cell below the first one always keeps its place, so
    // the first cell takes the new sample whenever its own sample is larger.
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic [7:0]       lv;
        logic [AGE_W-1:0] la;
        logic             lo;
        logic             lk;
        logic             lp;
        logic [7:0]       rv;
        logic [AGE_W-1:0] ra;
        logic             ro;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign la = '0;
            assign lo = 1'b0;
            assign lk = 1'b1;
            assign lp = 1'b0;
        end
        else
        begin : g_inner
            assign lv = cell_val[i-1];
            assign la = cell_age[i-1];
            assign lo = cell_occ[i-1];
            assign lk = cell_keep[i-1];
            assign lp = cell_passed[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_last
            assign rv = '0;
            assign ra = '0;
            assign ro = 1'b0;
        end
        else
        begin : g_body
            assign rv = cell_val[i+1];
            assign ra = cell_age[i+1];
            assign ro = cell_occ[i+1];
        end

        swm_cell #(
            .AGE_W(AGE_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .oldest_age   (oldest_age),
            .left_sample  (lv),
            .left_age     (la),
            .left_occ     (lo),
            .left_keep    (lk),
            .passed_in    (lp),
            .right_sample (rv),
            .right_age    (ra),
            .right_occ    (ro),
            .val          (cell_val[i]),
            .age          (cell_age[i]),
            .occ          (cell_occ[i]),
            .keep         (cell_keep[i]),
            .passed_out   (cell_passed[i])
        );
    end

    // The median sits in the cell at index count/2 of the sorted chain. An empty
    // window has no occupied cell there and so selects 0.
    assign mid_rank = count_reg >> 1;

    always_comb
    begin
        median_sel = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (cell_occ[i] && (CNT_W'(i) == mid_rank))
            begin
                median_sel = median_sel | cell_val[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rej_reg <= pend_rej_next;
        if (load_out)
        begin
            median_reg   <= median_sel;
            fill_reg     <= 7'(count_reg);
            full_reg     <= win_full;
            empty_reg    <= win_empty;
            rejected_reg <= pend_rej_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign median     = median_reg;
    assign fill_count = fill_reg;
    assign is_full    = full_reg;
    assign is_empty   = empty_reg;
    assign rejected   = rejected_reg;

endmodule

>>> hdl/swm_checker.sv
// Port-level checks for the sliding-window median, bound to the top level.
`timescale 1ns / 1ps

module swm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       func,
    input logic [7:0] sample,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] median,
    input logic [6:0] fill_count,
    input logic       is_full,
    input logic       is_empty,
    input logic       rejected
);

    // A window cannot be full and empty at once.
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(is_full && is_empty))
        else $error("result shows full and empty together");

    // An empty window reports a zero median and a zero count.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && is_empty) |-> (median == 8'd0) && (fill_count == 7'd0))
        else $error("empty window with nonzero median or count");

    // A stalled result stays offered and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid && $stable(median)
            && $stable(fill_count) && $stable(rejected))
        else $error("stalled result changed");

    // No result appears without a request having been offered before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(res_valid) && !$past(req_valid)) |-> $past(req_valid, 2))
        else $error("result without a preceding request");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for the sliding-window median block.
`timescale 1ns / 1ps

module tb_top;

    // The window depth the block is built with in this bench.
    localparam int WINDOW_DEPTH = 64;
    // Longest wait that either side draws before a request or a result.
    localparam int MAX_WAIT = 11;
    // Number of requests in the random part of the run.
    localparam int RANDOM_REQUESTS = 950;

    // One result as the block reports it after a request.
    typedef struct packed {
        logic [7:0] median;
        logic [6:0] fill_count;
        logic       is_full;
        logic       is_empty;
        logic       rejected;
    } window_status_t;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    logic       func;
    logic [7:0] sample;
    logic       res_valid;
    logic       res_stall;
    logic [7:0] median;
    logic [6:0] fill_count;
    logic       is_full;
    logic       is_empty;
    logic       rejected;

    sliding_window_median #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .sample    (sample),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .median    (median),
        .fill_count(fill_count),
        .is_full   (is_full),
        .is_empty  (is_empty),
        .rejected  (rejected)
    );

    // Our own copy of the window, oldest sample at the front, and the results
    // still owed by the block, oldest first.
    logic [7:0]     window_q[$];
    window_status_t status_q[$];

    int error_count  = 0;
    int result_count = 0;
    int push_count   = 0;
    int pop_count    = 0;
    int reject_count = 0;
    int full_count   = 0;

    // Set by a test to make the result side refuse everything for that many
    // cycles; the sink process picks it up and counts the cycles itself.
    int hold_cycles = 0;
    // When set, neither side inserts any wait of its own.
    bit no_idle = 1'b0;

    // The clock runs at 50 MHz.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Waits are drawn so that roughly a third of the requests and results
    // see a pause, of any length up to MAX_WAIT.
    function automatic int draw_wait();
        if ($urandom_range(0, 2) == 0)
            return int'($urandom_range(1, MAX_WAIT));
        return 0;
    endfunction

    // Applies one accepted request to our window and works out the result the
    // block must report for it. A push into a full window and a pop from an
    // empty one leave the window alone and come back refused. The median is
    // the sample at ascending rank count/2, found by walking a histogram, so
    // for an even count it is the upper of the two middle samples.
    function automatic window_status_t apply_request(swm_pkg::swm_func_t op,
                                                     logic [7:0] value);
        window_status_t st;
        int             hist[256];
        int             acc;
        int             rank;
        st = '0;
        foreach (hist[v])
            hist[v] = 0;
        if (op == swm_pkg::FUNC_PUSH)
        begin
            push_count++;
            if (window_q.size() >= WINDOW_DEPTH)
                st.rejected = 1'b1;
            else
                window_q.push_back(value);
        end
        else
        begin
            pop_count++;
            if (window_q.size() == 0)
                st.rejected = 1'b1;
            else
                void'(window_q.pop_front());
        end
        if (window_q.size() != 0)
        begin
            foreach (window_q[i])
                hist[window_q[i]]++;
            rank = window_q.size() / 2;
            acc  = 0;
            for (int v = 0; v < 256; v++)
            begin
                acc += hist[v];
                if (acc > rank)
                begin
                    st.median = 8'(v);
                    break;
                end
            end
        end
        st.fill_count = 7'(window_q.size());
        st.is_full    = (window_q.size() >= WINDOW_DEPTH);
        st.is_empty   = (window_q.size() == 0);
        if (st.rejected)
            reject_count++;
        if (st.is_full)
            full_count++;
        return st;
    endfunction

    // Offers one request after an optional random pause and returns right
    // after the clock edge that took it. Valid stays high on return, so a
    // following request with no pause goes out back to back; anything that
    // waits afterwards must lower valid first.
    task automatic send_request(swm_pkg::swm_func_t op, logic [7:0] value);
        int gap;
        gap = no_idle ? 0 : draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= op;
        sample    <= value;
        do
            @(posedge clk);
        while (req_stall);
        status_q.push_back(apply_request(op, value));
    endtask

    // The sample field of a pop carries random bits, since the block must
    // ignore it.
    task automatic send_pop();
        send_request(swm_pkg::FUNC_POP, 8'($urandom_range(0, 255)));
    endtask

    // Stops offering requests until every owed result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    // Every result taken by the bench is held against the oldest one owed.
    always @(posedge clk)
    begin : result_check
        window_status_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            result_count++;
            if (status_q.size() == 0)
            begin
                $error("result with none owed: median %0d, fill_count %0d", median, fill_count);
                error_count++;
            end
            else
            begin
                want = status_q.pop_front();
                check_field("median", want.median, median);
                check_field("fill_count", 8'(want.fill_count), 8'(fill_count));
                check_field("is_full", 8'(want.is_full), 8'(is_full));
                check_field("is_empty", 8'(want.is_empty), 8'(is_empty));
                check_field("rejected", 8'(want.rejected), 8'(rejected));
            end
        end
    end

    // The result side stalls for a freshly drawn number of cycles after each
    // result it takes. A long hold asked for by a test overrides that draw.
    initial
    begin : result_sink
        int wait_left;
        wait_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                wait_left   = hold_cycles;
                hold_cycles = 0;
            end
            else if (rst_n && res_valid && !res_stall)
                wait_left = no_idle ? 0 : draw_wait();
            if (wait_left > 0)
            begin
                res_stall <= 1'b1;
                wait_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Empty-window refusal, the byte extremes, duplicate samples, odd and
    // even counts, and a full walk back down to empty.
    task automatic test_directed_edges();
        send_pop();
        send_request(swm_pkg::FUNC_PUSH, 8'h00);
        send_request(swm_pkg::FUNC_PUSH, 8'hFF);
        send_request(swm_pkg::FUNC_PUSH, 8'h80);
        send_request(swm_pkg::FUNC_PUSH, 8'h80);
        send_request(swm_pkg::FUNC_PUSH, 8'h01);
        send_request(swm_pkg::FUNC_PUSH, 8'hFE);
        repeat (6) send_pop();
        send_pop();
        send_request(swm_pkg::FUNC_PUSH, 8'hFF);
        send_request(swm_pkg::FUNC_PUSH, 8'h00);
        send_pop();
        send_pop();
        send_pop();
        drain_results();
    endtask

    // Fills the window to the top, checks that further pushes bounce off,
    // frees one slot and fills it, then empties the window completely.
    task automatic test_full_window();
        repeat (WINDOW_DEPTH) send_request(swm_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
        send_request(swm_pkg::FUNC_PUSH, 8'h00);
        send_request(swm_pkg::FUNC_PUSH, 8'hFF);
        send_pop();
        send_request(swm_pkg::FUNC_PUSH, 8'hAA);
        send_request(swm_pkg::FUNC_PUSH, 8'h55);
        repeat (WINDOW_DEPTH) send_pop();
        send_pop();
        drain_results();
    endtask

    // The result side refuses everything for a long stretch while requests
    // keep coming back to back, so the block backs up and stalls its input.
    task automatic test_backpressure();
        no_idle     = 1'b1;
        hold_cycles = 60;
        repeat (40) send_request(swm_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
        hold_cycles = 45;
        repeat (42) send_pop();
        no_idle = 1'b0;
        drain_results();
    endtask

    // Bursts of requests separated by full stops, where the sender waits
    // for every result before going on.
    task automatic test_drain_pause();
        repeat (4)
        begin
            repeat ($urandom_range(3, 12))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_pop();
                else
                    send_request(swm_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)));
            end
            drain_results();
        end
    endtask

    // Random traffic in phases. Each phase leans toward filling, toward
    // emptying, or neither, and draws its samples from the full byte range,
    // from a narrow band that yields many duplicates, or from the two
    // extremes only. Some phases run with no waits on either side.
    task automatic test_random_traffic(int total);
        int         sent;
        int         phase_len;
        int         push_pct;
        int         value_mode;
        int         band_lo;
        logic [7:0] value;
        sent = 0;
        while (sent < total)
        begin
            phase_len  = $urandom_range(20, 80);
            value_mode = $urandom_range(0, 3);
            band_lo    = $urandom_range(0, 250);
            case ($urandom_range(0, 3))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            repeat (phase_len)
            begin
                case (value_mode)
                    0:       value = 8'($urandom_range(band_lo, band_lo + 5));
                    1:       value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: value = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(1, 100) <= push_pct)
                    send_request(swm_pkg::FUNC_PUSH, value);
                else
                    send_pop();
                sent++;
            end
            no_idle = 1'b0;
            // Now and then the sender stops until the block has caught up.
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Every input is known from time zero, reset is held low at the start and
    // released once, and the tests then run in order.
    initial
    begin : test_sequence
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        func      <= swm_pkg::FUNC_PUSH;
        sample    <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_full_window();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(RANDOM_REQUESTS);

        // Give a stray extra result time to show up.
        repeat (20) @(posedge clk);

        $display("Sent %0d pushes and %0d pops, %0d refused; window full after %0d of them.",
                 push_count, pop_count, reject_count, full_count);
        $display("Checked %0d results, %0d mismatches.", result_count, error_count);
        if (error_count == 0)
            $display("PASS sliding_window_median");
        else
            $display("FAIL sliding_window_median");
        $finish;
    end

    // A correct run ends well within a tenth of this time.
    initial
    begin : watchdog
        #10ms;
        $display("Timed out with %0d results still owed.", status_q.size());
        $display("FAIL sliding_window_median");
        $finish;
    end

endmodule
